>>> src/mrrc_pkg.sv
// package: shared types, codes and the crc byte update for the modbus read response checker
`timescale 1ns / 1ps

package mrrc_pkg;

    localparam int MAX_REGS = 64;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  MIN_FRAME         = 8'd5;

    // input mode codes
    localparam logic [1:0] MODE_DATA = 2'd0;
    localparam logic [1:0] MODE_LAST = 2'd1;
    localparam logic [1:0] MODE_END  = 2'd2;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // register indexes on the configuration port
    localparam logic REG_EXPECTED_ADDRESS = 1'b0;
    localparam logic REG_REGISTER_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        HDR_OK    = 2'd0,
        HDR_ADDR  = 2'd1,
        HDR_COUNT = 2'd2
    } header_error_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NONE     = 3'd1,
        ST_SHORT    = 3'd2,
        ST_ADDR     = 3'd3,
        ST_COUNT    = 3'd4,
        ST_CRC      = 3'd5,
        ST_CAPACITY = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] expected_address;
        logic [6:0] register_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } request_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  word_index;
        logic [15:0] word_value;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } step_result_t;

    // one byte of reflected crc-16, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

>>> src/mrrc_if.sv
// valid/ready channel interfaces for incoming bytes and outgoing results
`timescale 1ns / 1ps

interface mrrc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface mrrc_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [5:0]  word_index;
    logic [15:0] word_value;
    logic [2:0]  status;

    modport source (output valid, output kind, output word_index, output word_value,
                    output status, input ready);
    modport sink   (input valid, input kind, input word_index, input word_value,
                    input status, output ready);
endinterface

>>> src/modbus_read_response_checker.sv
// top level: modbus rtu read holding registers response checker
`timescale 1ns / 1ps

// usage
// - byte_chan carries one request per received byte: mode 0 data byte, mode 1
//   final byte of the frame, mode 2 (or 3) end of frame with no byte
// - result_chan carries register words (kind 0) under index 64 when the low byte
//   comes in mode 0, one status (kind 1) per frame end; commit words only on ok
// - apb port holds expected_address at 0x0 and register_count at 0x4;
//   write them only while no request is in flight
// an accepted request waits in the input register; its result is loaded into the
//   output register once that register is free to take it
// throughput: one request per cycle unless result_chan stalls; the crc byte update
//   and all checks are one combinational pass between input and output registers
// a request that causes no result still moves through and updates the frame
// when result_chan stalls, the output register holds its result, the input
//   register holds its request, and byte_chan.ready falls only when both are full
// reset: frame state clears (crc 0xffff), both registers empty, expected_address
//   and register_count return to 1
module modbus_read_response_checker (
    input  logic               clk,
    input  logic               rst_n,
    mrrc_in_if.sink            byte_chan,
    mrrc_out_if.source         result_chan,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    mrrc_pkg::cfg_t            cfg;
    mrrc_pkg::request_t        req_reg;
    logic                      req_valid_reg;
    mrrc_pkg::result_t         out_reg;
    logic                      out_valid_reg;
    mrrc_pkg::step_result_t    step_res;
    logic                      advance;
    logic                      out_free;

    mrrc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // output register can take a new result this cycle
    assign out_free        = !out_valid_reg || result_chan.ready;
    // held request steps the frame and moves into the output stage
    assign advance         = req_valid_reg && out_free;
    assign byte_chan.ready = !req_valid_reg || out_free;

    mrrc_frame_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (byte_chan.ready)
            req_valid_reg <= byte_chan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_chan.valid && byte_chan.ready)
        begin
            req_reg.mode    <= byte_chan.mode;
            req_reg.rx_byte <= byte_chan.rx_byte;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance && step_res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_res.valid)
            out_reg <= step_res.data;
    end

    assign result_chan.valid      = out_valid_reg;
    assign result_chan.kind       = out_reg.kind;
    assign result_chan.word_index = out_reg.word_index;
    assign result_chan.word_value = out_reg.word_value;
    assign result_chan.status     = out_reg.status;

endmodule

>>> src/mrrc_cfg_regs.sv
// apb-style configuration registers: expected slave address and register count
`timescale 1ns / 1ps

module mrrc_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mrrc_pkg::cfg_t      cfg
);

    logic [7:0] expected_address_reg;
    logic [6:0] register_count_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_address_reg <= 8'd1;
            register_count_reg   <= 7'd1;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                mrrc_pkg::REG_EXPECTED_ADDRESS: expected_address_reg <= pwdata[7:0];
                mrrc_pkg::REG_REGISTER_COUNT:   register_count_reg   <= pwdata[6:0];
                default:                        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            mrrc_pkg::REG_EXPECTED_ADDRESS: prdata = {24'd0, expected_address_reg};
            mrrc_pkg::REG_REGISTER_COUNT:   prdata = {25'd0, register_count_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    assign cfg.expected_address = expected_address_reg;
    assign cfg.register_count   = register_count_reg;

endmodule

>>> src/mrrc_frame_core.sv
// frame state and single-pass byte step: crc, header checks, word assembly, status
`timescale 1ns / 1ps

module mrrc_frame_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  mrrc_pkg::request_t         req,
    input  mrrc_pkg::cfg_t             cfg,
    output mrrc_pkg::step_result_t     res
);

    logic [7:0]                byte_position_reg, byte_position_next;
    logic [15:0]               running_crc_reg, running_crc_next;
    logic [7:0]                high_byte_hold_reg, high_byte_hold_next;
    logic [15:0]               received_crc_reg, received_crc_next;
    mrrc_pkg::header_error_t   header_error_reg, header_error_next;

    logic [8:0]  data_end;
    logic [8:0]  frame_len;
    logic [8:0]  pos9;
    logic        is_byte;
    logic        take;
    logic [7:0]  off;
    logic [6:0]  word_idx;
    logic        word_ready;
    logic [7:0]  want;
    mrrc_pkg::status_t st;

    assign data_end  = {1'b0, cfg.register_count, 1'b0} + 9'd3;
    assign frame_len = data_end + 9'd2;
    assign pos9      = {1'b0, byte_position_reg};
    assign is_byte   = req.mode inside {mrrc_pkg::MODE_DATA, mrrc_pkg::MODE_LAST};
    assign take      = is_byte && (pos9 < frame_len) && (byte_position_reg != 8'hFF);
    assign off       = byte_position_reg - 8'd3;
    assign want      = (byte_position_reg == 8'd0) ? cfg.expected_address
                                                   : mrrc_pkg::FUNC_READ_HOLDING;

    always_comb
    begin
        byte_position_next  = byte_position_reg;
        running_crc_next    = running_crc_reg;
        high_byte_hold_next = high_byte_hold_reg;
        received_crc_next   = received_crc_reg;
        header_error_next   = header_error_reg;
        word_idx            = off[7:1];
        word_ready          = 1'b0;

        if (take)
        begin
            if (pos9 < data_end)
                running_crc_next = mrrc_pkg::crc_byte(running_crc_reg, req.rx_byte);

            if (byte_position_reg == 8'd0 || byte_position_reg == 8'd1)
            begin
                if (req.rx_byte != want && header_error_reg == mrrc_pkg::HDR_OK)
                    header_error_next = mrrc_pkg::HDR_ADDR;
            end
            else if (byte_position_reg == 8'd2)
            begin
                if (req.rx_byte != {cfg.register_count, 1'b0}
                    && header_error_reg == mrrc_pkg::HDR_OK)
                    header_error_next = mrrc_pkg::HDR_COUNT;
            end
            else if (pos9 < data_end)
            begin
                if (!off[0])
                    high_byte_hold_next = req.rx_byte;
                else
                    word_ready = word_idx < 7'(mrrc_pkg::MAX_REGS);
            end
            else if (pos9 == data_end)
                received_crc_next = {received_crc_reg[15:8], req.rx_byte};
            else
                received_crc_next = {req.rx_byte, received_crc_reg[7:0]};

            byte_position_next = byte_position_reg + 8'd1;
        end

        // status in order of checks, from the updated frame state
        if (byte_position_next == 8'd0)
            st = mrrc_pkg::ST_NONE;
        else if (byte_position_next < mrrc_pkg::MIN_FRAME)
            st = mrrc_pkg::ST_SHORT;
        else if (header_error_next == mrrc_pkg::HDR_ADDR)
            st = mrrc_pkg::ST_ADDR;
        else if (header_error_next == mrrc_pkg::HDR_COUNT)
            st = mrrc_pkg::ST_COUNT;
        else if ({1'b0, byte_position_next} != frame_len
                 || running_crc_next != received_crc_next)
            st = mrrc_pkg::ST_CRC;
        else if (cfg.register_count > 7'(mrrc_pkg::MAX_REGS))
            st = mrrc_pkg::ST_CAPACITY;
        else
            st = mrrc_pkg::ST_OK;

        if (req.mode == mrrc_pkg::MODE_DATA)
        begin
            res.valid           = word_ready;
            res.data.kind       = mrrc_pkg::KIND_WORD;
            res.data.word_index = word_idx[5:0];
            res.data.word_value = {high_byte_hold_reg, req.rx_byte};
            res.data.status     = mrrc_pkg::ST_OK;
        end
        else
        begin
            res.valid           = 1'b1;
            res.data.kind       = mrrc_pkg::KIND_STATUS;
            res.data.word_index = 6'd0;
            res.data.word_value = 16'd0;
            res.data.status     = st;
            // frame done: back to reset values
            byte_position_next  = 8'd0;
            running_crc_next    = mrrc_pkg::CRC_INIT;
            high_byte_hold_next = 8'd0;
            received_crc_next   = 16'd0;
            header_error_next   = mrrc_pkg::HDR_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg  <= 8'd0;
            running_crc_reg    <= mrrc_pkg::CRC_INIT;
            high_byte_hold_reg <= 8'd0;
            received_crc_reg   <= 16'd0;
            header_error_reg   <= mrrc_pkg::HDR_OK;
        end
        else if (step_en)
        begin
            byte_position_reg  <= byte_position_next;
            running_crc_reg    <= running_crc_next;
            high_byte_hold_reg <= high_byte_hold_next;
            received_crc_reg   <= received_crc_next;
            header_error_reg   <= header_error_next;
        end
    end

endmodule

>>> bench/modbus_read_response_checker_tb.sv
// testbench: streams modbus read responses byte by byte and checks words and frame status
`timescale 1ns / 1ps

module modbus_read_response_checker_tb;

    // the fourth mode code is unused by the block and must act as a frame end
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RANDOM_REQUESTS  = 720;
    localparam int DRAIN_CYCLES     = 4;
    localparam int MAX_IDLE         = 13;

    // how a frame is closed on the byte channel
    typedef enum {
        TERM_ON_LAST,
        TERM_MARKER,
        TERM_UNUSED_MODE
    } frame_end_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mrrc_in_if  byte_chan ();
    mrrc_out_if result_chan ();

    modbus_read_response_checker i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_chan   (byte_chan),
        .result_chan (result_chan),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // configuration as the block should hold it
    logic [7:0]    cfg_slave_addr;
    logic [6:0]    cfg_reg_count;

    // frame state of the predicted parser
    logic [7:0]    frm_pos;
    logic [15:0]   frm_crc;
    logic [7:0]    frm_hi;
    logic [15:0]   frm_rx_crc;
    mrrc_pkg::header_error_t frm_hdr;

    // words and statuses the block still owes, oldest first
    mrrc_pkg::result_t outputs_due [$];
    mrrc_pkg::result_t oldest_due;

    // bytes of the frame about to be sent
    logic [7:0]    frame_q [$];

    int            error_count;
    int            requests_sent;
    int            cycle_count;
    int            src_max_gap;
    int            sink_max_gap;
    int            sink_hold_cycles;

    // ------------------------------------------------------------------
    // clock and run limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // a run that hangs on a missing result or a stuck ready ends here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("modbus_read_response_checker test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // predicted parser
    // ------------------------------------------------------------------

    // reflected crc-16, one data bit per step, lsb first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[15:1]};
            if (fb)
                c = c ^ mrrc_pkg::CRC_POLY;
        end
        return c;
    endfunction

    task automatic clear_frame_state();
        frm_pos    = 8'd0;
        frm_crc    = mrrc_pkg::CRC_INIT;
        frm_hi     = 8'd0;
        frm_rx_crc = 16'd0;
        frm_hdr    = mrrc_pkg::HDR_OK;
    endtask

    // one accepted request: update the frame and queue whatever the block must emit
    task automatic parse_response_byte(input logic [1:0] mode, input logic [7:0] b);
        logic [8:0] data_end;
        logic [8:0] frame_len;
        logic [8:0] off;
        logic [7:0] p;
        logic [7:0] word_idx;
        logic       word_done;
        mrrc_pkg::status_t st;
        data_end  = 9'd3 + {1'b0, cfg_reg_count, 1'b0};
        frame_len = data_end + 9'd2;
        word_idx  = 8'd0;
        word_done = 1'b0;
        // position saturates at 255, and bytes past the frame length are dropped
        if (mode <= mrrc_pkg::MODE_LAST && {1'b0, frm_pos} < frame_len && frm_pos != 8'hFF)
        begin
            p = frm_pos;
            if ({1'b0, p} < data_end)
                frm_crc = crc16_step(frm_crc, b);
            if (p <= 8'd1)
            begin
                // first header fault wins
                if (b != ((p == 8'd0) ? cfg_slave_addr : mrrc_pkg::FUNC_READ_HOLDING)
                    && frm_hdr == mrrc_pkg::HDR_OK)
                    frm_hdr = mrrc_pkg::HDR_ADDR;
            end
            else if (p == 8'd2)
            begin
                if (b != {cfg_reg_count, 1'b0} && frm_hdr == mrrc_pkg::HDR_OK)
                    frm_hdr = mrrc_pkg::HDR_COUNT;
            end
            else if ({1'b0, p} < data_end)
            begin
                off = {1'b0, p} - 9'd3;
                if (!off[0])
                    frm_hi = b;
                else
                begin
                    word_idx  = off[8:1];
                    word_done = (word_idx < mrrc_pkg::MAX_REGS);
                end
            end
            else if ({1'b0, p} == data_end)
                frm_rx_crc[7:0] = b;
            else
                frm_rx_crc[15:8] = b;
            frm_pos = p + 8'd1;
        end

        if (mode == mrrc_pkg::MODE_DATA)
        begin
            if (word_done)
                outputs_due.push_back('{mrrc_pkg::KIND_WORD, word_idx[5:0], {frm_hi, b},
                                        mrrc_pkg::ST_OK});
        end
        else
        begin
            // a word completed by the final byte is swallowed, only the status goes out
            if (frm_pos == 8'd0)
                st = mrrc_pkg::ST_NONE;
            else if (frm_pos < mrrc_pkg::MIN_FRAME)
                st = mrrc_pkg::ST_SHORT;
            else if (frm_hdr == mrrc_pkg::HDR_ADDR)
                st = mrrc_pkg::ST_ADDR;
            else if (frm_hdr == mrrc_pkg::HDR_COUNT)
                st = mrrc_pkg::ST_COUNT;
            else if ({1'b0, frm_pos} != frame_len || frm_crc != frm_rx_crc)
                st = mrrc_pkg::ST_CRC;
            else if (cfg_reg_count > mrrc_pkg::MAX_REGS)
                st = mrrc_pkg::ST_CAPACITY;
            else
                st = mrrc_pkg::ST_OK;
            outputs_due.push_back('{mrrc_pkg::KIND_STATUS, 6'd0, 16'd0, st});
            clear_frame_state();
        end
    endtask

    // ------------------------------------------------------------------
    // result side: random ready, optional long hold, and the compare
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        int hold;
        result_chan.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                // long hold so the block fills up and stops taking bytes
                hold = sink_hold_cycles;
                sink_hold_cycles = 0;
                result_chan.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            else
            begin
                gap = (sink_max_gap > 0) ? $urandom_range(0, sink_max_gap) : 0;
                if (gap > 0)
                begin
                    result_chan.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            result_chan.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_chan.valid);
            @(negedge clk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_chan.valid && result_chan.ready)
        begin
            if (outputs_due.size() == 0)
            begin
                $error("result with nothing pending: kind %0d index %0d value %0d status %0d",
                       result_chan.kind, result_chan.word_index, result_chan.word_value,
                       result_chan.status);
                error_count++;
            end
            else
            begin
                oldest_due = outputs_due.pop_front();
                check_field("kind", oldest_due.kind, result_chan.kind);
                check_field("word_index", oldest_due.word_index, result_chan.word_index);
                check_field("word_value", oldest_due.word_value, result_chan.word_value);
                check_field("status", oldest_due.status, result_chan.status);
            end
        end
    end

    // ------------------------------------------------------------------
    // request side and configuration port; all called at a falling edge
    // ------------------------------------------------------------------

    // valid stays high into the next request unless a gap is drawn
    task automatic send_request(input logic [1:0] mode, input logic [7:0] b);
        int gap;
        gap = (src_max_gap > 0) ? $urandom_range(0, src_max_gap) : 0;
        if (gap > 0)
        begin
            byte_chan.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_chan.valid   <= 1'b1;
        byte_chan.mode    <= mode;
        byte_chan.rx_byte <= b;
        do
            @(posedge clk);
        while (!byte_chan.ready);
        parse_response_byte(mode, b);
        requests_sent++;
        @(negedge clk);
    endtask

    // drop valid, let every owed result arrive, then let in-flight bytes settle
    task automatic wait_idle();
        byte_chan.valid <= 1'b0;
        while (outputs_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // setup, access, then idle with psel low before the next transfer
    task automatic apb_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == mrrc_pkg::REG_EXPECTED_ADDRESS)
            cfg_slave_addr = value[7:0];
        else
            cfg_reg_count = value[6:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [7:0] addr, input logic [6:0] count);
        wait_idle();
        apb_write(mrrc_pkg::REG_EXPECTED_ADDRESS, {24'd0, addr});
        apb_write(mrrc_pkg::REG_REGISTER_COUNT, {25'd0, count});
    endtask

    // idle limit for one side: none, full, or something between
    function automatic int pick_gap_limit();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return MAX_IDLE;
            default: return $urandom_range(1, MAX_IDLE - 1);
        endcase
    endfunction

    // header, data bytes (random when fill is negative), then crc low and high
    task automatic make_frame(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] count_byte, input int n_data, input int fill);
        logic [15:0] c;
        frame_q.delete();
        frame_q.push_back(addr);
        frame_q.push_back(func);
        frame_q.push_back(count_byte);
        for (int i = 0; i < n_data; i++)
            frame_q.push_back((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        c = mrrc_pkg::CRC_INIT;
        foreach (frame_q[i])
            c = crc16_step(c, frame_q[i]);
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endtask

    task automatic send_frame(input frame_end_t term);
        for (int i = 0; i < frame_q.size(); i++)
            send_request((term == TERM_ON_LAST && i == frame_q.size() - 1) ?
                         mrrc_pkg::MODE_LAST : mrrc_pkg::MODE_DATA, frame_q[i]);
        // the byte sent with an end code is junk and must be ignored
        if (term == TERM_UNUSED_MODE)
            send_request(MODE_UNUSED, 8'($urandom_range(0, 255)));
        else if (term == TERM_MARKER || frame_q.size() == 0)
            send_request(mrrc_pkg::MODE_END, 8'($urandom_range(0, 255)));
    endtask

    // mostly clean frames, the rest with one kind of damage
    task automatic random_frame();
        int           pick;
        int           cut;
        int           k;
        int           tpick;
        logic [7:0]   addr;
        logic [7:0]   func;
        logic [7:0]   cnt;
        frame_end_t   term;
        pick = $urandom_range(0, 99);
        addr = cfg_slave_addr;
        func = mrrc_pkg::FUNC_READ_HOLDING;
        cnt  = {cfg_reg_count, 1'b0};
        if (pick >= 55 && pick < 62)
            addr = addr ^ 8'($urandom_range(1, 255));
        else if (pick >= 62 && pick < 67)
            func = func ^ 8'($urandom_range(1, 255));
        else if (pick >= 67 && pick < 73)
            cnt = cnt ^ 8'($urandom_range(1, 255));
        make_frame(addr, func, cnt, 2 * cfg_reg_count, -1);

        if (pick >= 73 && pick < 80)
        begin
            // single bit error somewhere in the frame
            k = $urandom_range(0, frame_q.size() - 1);
            frame_q[k] = frame_q[k] ^ (8'd1 << $urandom_range(0, 7));
        end
        else if (pick >= 80 && pick < 86)
        begin
            // truncated, possibly down to nothing
            cut = $urandom_range(1, frame_q.size());
            repeat (cut) void'(frame_q.pop_back());
        end
        else if (pick >= 86 && pick < 92)
        begin
            // trailing garbage past the crc
            repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick >= 92 && pick < 97)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (pick >= 97)
            frame_q.delete();

        tpick = $urandom_range(0, 9);
        term  = (tpick < 5) ? TERM_ON_LAST : ((tpick < 8) ? TERM_MARKER : TERM_UNUSED_MODE);
        send_frame(term);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset config: slave 1, one register
    task automatic test_directed();
        src_max_gap  = 0;
        sink_max_gap = 0;
        // no response, with both end codes
        send_request(mrrc_pkg::MODE_END, 8'hA7);
        send_request(MODE_UNUSED, 8'h00);
        // three bytes only
        frame_q.delete();
        frame_q.push_back(8'h01);
        frame_q.push_back(mrrc_pkg::FUNC_READ_HOLDING);
        frame_q.push_back(8'h02);
        send_frame(TERM_MARKER);
        // clean frame, all-ones register
        make_frame(8'h01, mrrc_pkg::FUNC_READ_HOLDING, 8'h02, 2, 8'hFF);
        send_frame(TERM_ON_LAST);
        // final byte completes a word: truncated and the word is not emitted
        make_frame(8'h01, mrrc_pkg::FUNC_READ_HOLDING, 8'h02, 2, 8'h00);
        repeat (2) void'(frame_q.pop_back());
        send_frame(TERM_ON_LAST);
        // wrong slave address
        frame_q.delete();
        frame_q.push_back(8'hFE);
        frame_q.push_back(mrrc_pkg::FUNC_READ_HOLDING);
        frame_q.push_back(8'h02);
        frame_q.push_back(8'h11);
        frame_q.push_back(8'h22);
        send_frame(TERM_ON_LAST);
    endtask

    // register extremes: empty frame, capacity limit, oversized counts that saturate
    task automatic test_config_extremes();
        logic [7:0] addr_set  [7];
        logic [6:0] count_set [7];
        addr_set  = '{8'h00, 8'hFF, 8'h5A, 8'hC3, 8'h80, 8'h01, 8'h3C};
        count_set = '{7'd0, 7'd125, 7'd64, 7'd65, 7'd127, 7'd126, 7'd1};
        for (int i = 0; i < 7; i++)
        begin
            set_config(addr_set[i], count_set[i]);
            src_max_gap  = pick_gap_limit();
            sink_max_gap = pick_gap_limit();
            make_frame(addr_set[i], mrrc_pkg::FUNC_READ_HOLDING, {count_set[i], 1'b0},
                       2 * count_set[i], -1);
            send_frame((i % 2 == 0) ? TERM_ON_LAST : TERM_MARKER);
        end
    endtask

    // results pile up behind a long stall while bytes keep coming back to back
    task automatic test_output_stall();
        set_config(8'h11, 7'd20);
        src_max_gap      = 0;
        sink_max_gap     = 0;
        sink_hold_cycles = 300;
        make_frame(8'h11, mrrc_pkg::FUNC_READ_HOLDING, 8'd40, 40, -1);
        send_frame(TERM_ON_LAST);
    endtask

    task automatic test_random_frames();
        int start;
        int frames;
        int pick;
        start  = requests_sent;
        frames = 0;
        while (requests_sent - start < RANDOM_REQUESTS)
        begin
            // new settings every few frames, mostly small counts
            if (frames % 6 == 0)
            begin
                pick = $urandom_range(0, 99);
                set_config(8'($urandom_range(0, 255)),
                           (pick < 85) ? 7'($urandom_range(0, 6)) :
                           (pick < 95) ? 7'($urandom_range(7, 64)) :
                                         7'($urandom_range(65, 127)));
            end
            src_max_gap  = pick_gap_limit();
            sink_max_gap = pick_gap_limit();
            random_frame();
            frames++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = 3'd0;
        pwdata            = 32'd0;
        byte_chan.valid   = 1'b0;
        byte_chan.mode    = mrrc_pkg::MODE_DATA;
        byte_chan.rx_byte = 8'd0;
        error_count       = 0;
        requests_sent     = 0;
        src_max_gap       = 0;
        sink_max_gap      = 0;
        sink_hold_cycles  = 0;
        cfg_slave_addr    = 8'd1;
        cfg_reg_count     = 7'd1;
        clear_frame_state();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_config_extremes();
        test_output_stall();
        test_random_frames();
        wait_idle();

        if (error_count == 0)
            $display("modbus_read_response_checker test passed");
        else
            $display("modbus_read_response_checker test failed");
        $finish;
    end

endmodule
